/* rtl/cosine_gallery_match_defines.svh */
// assertion macros for the cosine gallery matcher
// expects clk and arst_n in the scope of use
`ifndef COSINE_GALLERY_MATCH_DEFINES_SVH
`define COSINE_GALLERY_MATCH_DEFINES_SVH

// same-cycle implication
`define CGM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cgm assertion failed");

// next-cycle implication
`define CGM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cgm assertion failed");

`endif

/* rtl/cgm_pkg.sv */
// types, sizes and codes for the cosine gallery matcher
// no dependencies
`timescale 1ns / 1ps
package cgm_pkg;
	localparam int MAX_ENTRIES = 64;
	localparam int MAX_DIM = 512;
	localparam int ENTRY_W = $clog2(MAX_ENTRIES);
	localparam int DIM_W = $clog2(MAX_DIM);
	localparam int CNT_W = ENTRY_W + 1;
	localparam int LEN_W = DIM_W + 1;
	localparam int GADDR_W = ENTRY_W + DIM_W;
	localparam int VAL_W = 16;
	localparam int THR_W = 15;
	localparam int GCNT_W = 7;
	localparam int VLEN_W = 10;
	localparam int CFG_W = 15;
	localparam int ACC_W = 2 * VAL_W + DIM_W;
	localparam int NRM_W = 2 * VAL_W - 1 + DIM_W;
	localparam int RAD_W = NRM_W + 6;
	localparam int ROOT_W = RAD_W / 2;
	localparam int DEN_W = 2 * ROOT_W;
	localparam int FRAC_SH = 21;
	localparam int NUM_W = ACC_W - 1 + FRAC_SH;
	localparam int Q_W = 17;
	localparam int REM_W = DEN_W + Q_W - 1;
	localparam int QCNT_W = $clog2(Q_W);

	typedef enum logic [1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_MARGIN    = 2'd1,
		CFG_COUNT     = 2'd2,
		CFG_LENGTH    = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STAT_UNKNOWN    = 2'd0,
		STAT_AMBIGUOUS  = 2'd1,
		STAT_IDENTIFIED = 2'd2
	} status_t;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef struct packed {
		logic                    kind;
		logic [ENTRY_W-1:0]      entry;
		logic [DIM_W-1:0]        element;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [ENTRY_W-1:0] best_entry;
		logic [THR_W-1:0]   similarity;
	} out_item_t;
endpackage

/* rtl/cgm_isqrt.sv */
// iterative integer square root, one result bit per cycle
// depends on cgm_pkg
`timescale 1ns / 1ps
module cgm_isqrt import cgm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);
	logic             busy_q;
	logic             done_q;
	logic [RAD_W-1:0] x_q;
	logic [RAD_W-1:0] res_q;
	logic [RAD_W-1:0] bit_q;
	logic [RAD_W:0]   trial;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == RAD_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
			bit_q <= RAD_W'(1) << (RAD_W - 2);
		end else if (busy_q) begin
			if ({1'b0, x_q} >= trial) begin
				x_q   <= x_q - trial[RAD_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];
endmodule

/* rtl/cosine_gallery_match.sv */
// cosine gallery matcher top level: stores, sequencer, ranking and decision
// depends on cgm_pkg, cgm_isqrt and cosine_gallery_match_defines.svh
// a last query item starts a search whose result comes once every entry is accumulated,
// rooted and divided, an entry with a zero norm skipping root and divide
// (one shared multiply-accumulate, root unit and restoring divider)
// throughput: one load item per cycle; no item is taken during a search
// reset: config to 0.60 / 0.05 / 0 entries / 512 elements, stores left unwritten
`timescale 1ns / 1ps
`include "cosine_gallery_match_defines.svh"
module cosine_gallery_match import cgm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_ACC    = 8'b0000_0010,
		S_SQA    = 8'b0000_0100,
		S_SQB    = 8'b0000_1000,
		S_MUL    = 8'b0001_0000,
		S_DIV    = 8'b0010_0000,
		S_RANK   = 8'b0100_0000,
		S_DECIDE = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [THR_W-1:0]  thr_q;
	logic [THR_W-1:0]  margin_q;
	logic [GCNT_W-1:0] gcount_q;
	logic [VLEN_W-1:0] vlen_q;

	logic signed [VAL_W-1:0] gal_mem [MAX_ENTRIES*MAX_DIM];
	logic signed [VAL_W-1:0] qry_mem [MAX_DIM];

	logic                    accept;
	logic [CNT_W-1:0]        count_eff;
	logic [LEN_W-1:0]        len_eff;
	logic [CNT_W-1:0]        e_q;
	logic [LEN_W-1:0]        i_q;
	logic                    rv_s1;
	logic                    pv_s2;
	logic signed [VAL_W-1:0] g_rd_s1;
	logic signed [VAL_W-1:0] q_rd_s1;
	logic signed [2*VAL_W-1:0] p_ab_s2;
	logic [2*VAL_W-2:0]      p_aa_s2;
	logic [2*VAL_W-2:0]      p_bb_s2;
	logic signed [ACC_W-1:0] dot_q;
	logic [NRM_W-1:0]        na_q;
	logic [NRM_W-1:0]        nb_q;
	logic                    acc_end;
	logic                    zero_q;
	logic                    sq_start;
	logic [RAD_W-1:0]        sq_rad;
	logic                    sq_done;
	logic [ROOT_W-1:0]       sq_root;
	logic [ROOT_W-1:0]       ra_q;
	logic [DEN_W-1:0]        den_q;
	logic [DEN_W-1:0]        den_w;
	logic [ACC_W-1:0]        mag;
	logic [REM_W-1:0]        rem_q;
	logic [REM_W-1:0]        dsh_q;
	logic [Q_W-1:0]          quo_q;
	logic [QCNT_W-1:0]       k_q;
	logic signed [VAL_W-1:0] score;
	logic signed [VAL_W-1:0] best_q;
	logic signed [VAL_W-1:0] second_q;
	logic [ENTRY_W-1:0]      best_idx_q;
	logic                    best_valid_q;
	logic                    sat;
	logic [VAL_W-1:0]        neg_mag;
	logic signed [VAL_W:0]   gap;
	logic                    out_valid_q;
	out_item_t               out_q;
	logic [1:0]              status_w;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	assign count_eff = (gcount_q > GCNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
		: CNT_W'(gcount_q);
	always_comb begin
		if (vlen_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (vlen_q > VLEN_W'(MAX_DIM)) begin
			len_eff = LEN_W'(MAX_DIM);
		end else begin
			len_eff = LEN_W'(vlen_q);
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_W'(19661);
			margin_q <= THR_W'(1638);
			gcount_q <= '0;
			vlen_q   <= VLEN_W'(512);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_THRESHOLD: thr_q    <= cfg_data;
				CFG_MARGIN:    margin_q <= cfg_data;
				CFG_COUNT:     gcount_q <= cfg_data[GCNT_W-1:0];
				CFG_LENGTH:    vlen_q   <= cfg_data[VLEN_W-1:0];
				default:       thr_q    <= thr_q;
			endcase
		end
	end

	// gallery and query stores
	always_ff @(posedge clk) begin
		if (accept && in_data.kind == KIND_LOAD) begin
			gal_mem[{in_data.entry, in_data.element}] <= in_data.value;
		end
		g_rd_s1 <= gal_mem[{e_q[ENTRY_W-1:0], i_q[DIM_W-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.kind == KIND_QUERY) begin
			qry_mem[in_data.element] <= in_data.value;
		end
		q_rd_s1 <= qry_mem[i_q[DIM_W-1:0]];
	end

	// products
	always_ff @(posedge clk) begin
		p_ab_s2 <= g_rd_s1 * q_rd_s1;
		p_aa_s2 <= (2*VAL_W-1)'(g_rd_s1 * g_rd_s1);
		p_bb_s2 <= (2*VAL_W-1)'(q_rd_s1 * q_rd_s1);
	end

	assign acc_end = (state_q == S_ACC) && (i_q == len_eff) && !rv_s1 && !pv_s2;
	assign sq_start = (acc_end && na_q != '0 && nb_q != '0) || (state_q == S_SQA && sq_done);
	assign sq_rad = (state_q == S_SQA) ? {nb_q, 6'b0} : {na_q, 6'b0};

	cgm_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign den_w = DEN_W'(ra_q) * DEN_W'(sq_root);
	assign mag = dot_q[ACC_W-1] ? ACC_W'(-dot_q) : ACC_W'(dot_q);

	assign sat = |quo_q[Q_W-1:VAL_W-1];
	assign neg_mag = VAL_W'(0) - {1'b0, quo_q[VAL_W-2:0]};
	always_comb begin
		if (zero_q) begin
			score = 16'sh8000;
		end else if (dot_q[ACC_W-1]) begin
			score = sat ? 16'sh8000 : $signed(neg_mag);
		end else begin
			score = sat ? 16'sh7fff : $signed({1'b0, quo_q[VAL_W-2:0]});
		end
	end

	assign gap = (VAL_W+1)'(best_q) - (VAL_W+1)'(second_q);
	always_comb begin
		if (!best_valid_q || best_q < $signed({1'b0, thr_q})) begin
			status_w = STAT_UNKNOWN;
		end else if (gap < $signed({2'b0, margin_q})) begin
			status_w = STAT_AMBIGUOUS;
		end else begin
			status_w = STAT_IDENTIFIED;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			e_q          <= '0;
			i_q          <= '0;
			rv_s1        <= 1'b0;
			pv_s2        <= 1'b0;
			best_q       <= 16'sh8000;
			second_q     <= 16'sh8000;
			best_idx_q   <= '0;
			best_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			pv_s2 <= rv_s1;
			rv_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && in_data.kind == KIND_QUERY && in_data.last) begin
						best_q       <= 16'sh8000;
						second_q     <= 16'sh8000;
						best_idx_q   <= '0;
						best_valid_q <= 1'b0;
						e_q          <= '0;
						i_q          <= '0;
						state_q      <= (count_eff == '0) ? S_DECIDE : S_ACC;
					end
				end
				S_ACC: begin
					if (i_q != len_eff) begin
						rv_s1 <= 1'b1;
						i_q   <= i_q + LEN_W'(1);
					end
					if (acc_end) begin
						state_q <= (na_q != '0 && nb_q != '0) ? S_SQA : S_RANK;
					end
				end
				S_SQA: begin
					if (sq_done) begin
						state_q <= S_SQB;
					end
				end
				S_SQB: begin
					if (sq_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (k_q == '0) begin
						state_q <= S_RANK;
					end
				end
				S_RANK: begin
					if (score > best_q) begin
						second_q     <= best_q;
						best_q       <= score;
						best_idx_q   <= e_q[ENTRY_W-1:0];
						best_valid_q <= 1'b1;
					end else if (score > second_q) begin
						second_q <= score;
					end
					e_q <= e_q + CNT_W'(1);
					i_q <= '0;
					state_q <= (e_q + CNT_W'(1) == count_eff) ? S_DECIDE : S_ACC;
				end
				S_DECIDE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_ACC && i_q == '0 && !rv_s1 && !pv_s2) begin
			dot_q <= '0;
			na_q  <= '0;
			nb_q  <= '0;
		end else if (pv_s2) begin
			dot_q <= dot_q + ACC_W'(p_ab_s2);
			na_q  <= na_q + NRM_W'(p_aa_s2);
			nb_q  <= nb_q + NRM_W'(p_bb_s2);
		end
		if (acc_end) begin
			zero_q <= (na_q == '0) || (nb_q == '0);
		end
		if (state_q == S_SQA && sq_done) begin
			ra_q <= sq_root;
		end
		if (state_q == S_SQB && sq_done) begin
			den_q <= den_w;
		end
		if (state_q == S_MUL) begin
			rem_q <= REM_W'({mag[ACC_W-2:0], FRAC_SH'(0)});
			dsh_q <= REM_W'(den_q) << (Q_W - 1);
			quo_q <= '0;
			k_q   <= QCNT_W'(Q_W - 1);
		end else if (state_q == S_DIV) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[Q_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[Q_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
			k_q   <= k_q - QCNT_W'(1);
		end
		if (state_q == S_DECIDE && (!out_valid_q || !out_stall)) begin
			out_q.status     <= status_w;
			out_q.best_entry <= best_idx_q;
			out_q.similarity <= best_q[VAL_W-1] ? '0 : best_q[THR_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`CGM_ASSERT_IMP(a_div_nonzero, state_q == S_DIV, den_q != '0)
	`CGM_ASSERT_IMP(a_rise_from_decide, $rose(out_valid_q), $past(state_q == S_DECIDE))
	`CGM_ASSERT_IMP(a_root_in_sqrt, sq_done, state_q == S_SQA || state_q == S_SQB)
	`CGM_ASSERT_NXT(a_walk_bound, state_q == S_ACC, i_q <= len_eff && e_q < count_eff)
endmodule
